>>> rtl/sed_pkg.sv
// Shared types, character codes and helper functions for the string escape decoder.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

    localparam int MAX_STRING_LEN = 65535;
    localparam int LEN_W          = 16;

    // Length counter stops at the smaller of the string limit and the field range.
    localparam logic [LEN_W-1:0] LEN_LIMIT =
        (MAX_STRING_LEN > 65535) ? 16'hFFFF : LEN_W'(MAX_STRING_LEN);

    localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;

    typedef struct packed {
        logic             esc;
        logic             oct_act;
        logic [8:0]       acc;
        logic [1:0]       ocnt;
        logic [LEN_W-1:0] count;
    } dec_state_t;

    typedef struct packed {
        logic [7:0]       data;
        logic             run_last;
        logic             done;
        logic [LEN_W-1:0] length;
    } result_t;

    typedef struct packed {
        logic hit;
        logic [7:0] code;
    } esc_map_t;

    function automatic logic is_octal(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_SEVEN]};
    endfunction

    function automatic esc_map_t map_escape(input logic [7:0] b);
        esc_map_t m;
        m.hit  = 1'b1;
        m.code = 8'h00;
        case (b)
            CH_BSLASH: m.code = CH_BSLASH;
            CH_DQUOTE: m.code = CH_DQUOTE;
            CH_SLASH:  m.code = CH_SLASH;
            CH_A:      m.code = CODE_BEL;
            CH_B:      m.code = CODE_BS;
            CH_F:      m.code = CODE_FF;
            CH_N:      m.code = CODE_LF;
            CH_R:      m.code = CODE_CR;
            CH_T:      m.code = CODE_TAB;
            CH_V:      m.code = CODE_VT;
            default:   m.hit  = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] c);
        return (c >= LEN_LIMIT) ? c : c + LEN_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/sed_decode.sv
// Combinational escape decode of one byte against the current decoder state.
`timescale 1ns / 1ps
`default_nettype none

module sed_decode (
    input  wire sed_pkg::dec_state_t st,
    input  wire logic [7:0]          in_byte,
    input  wire logic                in_last,
    output sed_pkg::dec_state_t      st_next,
    output logic                     emit_a,
    output logic                     emit_b,
    output sed_pkg::result_t         res_a,
    output sed_pkg::result_t         res_b
);

    sed_pkg::esc_map_t          map;
    logic                       digit;
    logic [8:0]                 acc_ext;
    logic [1:0]                 ocnt_inc;
    logic                       plain;
    logic [7:0]                 byte_a;
    logic [7:0]                 byte_b;
    logic [sed_pkg::LEN_W-1:0]  len_a;
    logic [sed_pkg::LEN_W-1:0]  len_b;

    always_comb
    begin
        st_next  = st;
        emit_a   = 1'b0;
        emit_b   = 1'b0;
        byte_a   = 8'h00;
        byte_b   = 8'h00;
        plain    = 1'b0;
        map      = sed_pkg::map_escape(in_byte);
        digit    = sed_pkg::is_octal(in_byte);
        acc_ext  = {st.acc[5:0], in_byte[2:0]};
        ocnt_inc = st.ocnt + 2'd1;

        if (st.oct_act)
        begin
            if (digit)
            begin
                st_next.acc  = acc_ext;
                st_next.ocnt = ocnt_inc;
                // third digit or string end flushes the value
                if (ocnt_inc == sed_pkg::OCT_MAX_DIGITS || in_last)
                begin
                    emit_a          = 1'b1;
                    byte_a          = acc_ext[7:0];
                    st_next.oct_act = 1'b0;
                    st_next.acc     = 9'd0;
                    st_next.ocnt    = 2'd0;
                end
            end
            else
            begin
                // non-digit ends the octal run, then decodes as a plain byte
                emit_a          = 1'b1;
                byte_a          = st.acc[7:0];
                st_next.oct_act = 1'b0;
                st_next.acc     = 9'd0;
                st_next.ocnt    = 2'd0;
                plain           = 1'b1;
            end
        end
        else if (st.esc)
        begin
            st_next.esc = 1'b0;
            if (map.hit)
            begin
                emit_a = 1'b1;
                byte_a = map.code;
            end
            else if (digit)
            begin
                st_next.oct_act = 1'b1;
                st_next.acc     = {6'd0, in_byte[2:0]};
                st_next.ocnt    = 2'd1;
                if (in_last)
                begin
                    emit_a = 1'b1;
                    byte_a = {5'd0, in_byte[2:0]};
                end
            end
            else
            begin
                // unknown escape: both bytes pass through
                emit_a = 1'b1;
                byte_a = sed_pkg::CH_BSLASH;
                emit_b = 1'b1;
                byte_b = in_byte;
            end
        end
        else
        begin
            plain = 1'b1;
        end

        if (plain)
        begin
            if (in_byte == sed_pkg::CH_BSLASH && !in_last)
            begin
                st_next.esc = 1'b1;
            end
            else if (emit_a)
            begin
                emit_b = 1'b1;
                byte_b = in_byte;
            end
            else
            begin
                emit_a = 1'b1;
                byte_a = in_byte;
            end
        end

        len_a = sed_pkg::len_inc(st.count);
        len_b = sed_pkg::len_inc(len_a);

        if (emit_b)
        begin
            st_next.count = len_b;
        end
        else if (emit_a)
        begin
            st_next.count = len_a;
        end

        // string end returns everything to the idle state
        if (in_last)
        begin
            st_next = '0;
        end

        res_a.data     = byte_a;
        res_a.run_last = !emit_b;
        res_a.done     = in_last && !emit_b;
        res_a.length   = len_a;
        res_b.data     = byte_b;
        res_b.run_last = 1'b1;
        res_b.done     = in_last;
        res_b.length   = len_b;
    end

endmodule

`default_nettype wire

>>> rtl/sed_out_queue.sv
// Two-entry result register queue; head entry drives the output word.
`timescale 1ns / 1ps
`default_nettype none

module sed_out_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_a,
    input  wire sed_pkg::result_t    res_a,
    input  wire logic                push_b,
    input  wire sed_pkg::result_t    res_b,
    input  wire logic                out_ready,
    output logic                     head_valid,
    output sed_pkg::result_t         head,
    output logic                     room
);

    sed_pkg::result_t ent0_reg;
    sed_pkg::result_t ent1_reg;
    sed_pkg::result_t ent0_next;
    sed_pkg::result_t ent1_next;
    logic [1:0]       occ_reg;
    logic [1:0]       occ_next;
    logic             pop;

    assign head_valid = (occ_reg != 2'd0);
    assign head       = ent0_reg;
    assign pop        = head_valid && out_ready;
    // room for a two-word burst once this cycle's pop is taken
    assign room       = (occ_reg == 2'd0) || (occ_reg == 2'd1 && pop);

    always_comb
    begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        occ_next  = occ_reg;
        if (pop)
        begin
            ent0_next = ent1_reg;
            occ_next  = occ_reg - 2'd1;
        end
        if (push_a)
        begin
            if (occ_next == 2'd0)
            begin
                ent0_next = res_a;
            end
            else
            begin
                ent1_next = res_a;
            end
            occ_next = occ_next + 2'd1;
        end
        if (push_b)
        begin
            ent1_next = res_b;
            occ_next  = occ_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 2'd0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

`default_nettype wire

>>> rtl/string_escape_decoder.sv
// Top level: streaming C-style backslash escape decoder with octal escapes.
// A word passes the input register, then the output queue register, before its first result shows.
// Throughput: one input word per cycle while m_axis_tready is high; a word that
// makes two results fills the two-entry output queue and stalls the input.
// Reset (rst_n low, asynchronous) clears decoder state, input and output valids.
// After reset the block starts a new string; tlast on input ends each string.
`timescale 1ns / 1ps
`default_nettype none

module string_escape_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [23:8] out_length
    output logic             m_axis_tlast,   // run_last
    output logic             m_axis_tuser    // string_done
);

    // input register
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;

    // decoder state, updated only when a word is decoded
    sed_pkg::dec_state_t st_reg;
    sed_pkg::dec_state_t st_next;

    logic                emit_a;
    logic                emit_b;
    sed_pkg::result_t    res_a;
    sed_pkg::result_t    res_b;
    logic                room;
    logic                fire;
    logic                head_valid;
    sed_pkg::result_t    head;

    // decode the held word only when the queue can absorb two results
    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    sed_decode u_decode (
        .st      (st_reg),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .st_next (st_next),
        .emit_a  (emit_a),
        .emit_b  (emit_b),
        .res_a   (res_a),
        .res_b   (res_b)
    );

    sed_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_a     (fire && emit_a),
        .res_a      (res_a),
        .push_b     (fire && emit_b),
        .res_b      (res_b),
        .out_ready  (m_axis_tready),
        .head_valid (head_valid),
        .head       (head),
        .room       (room)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {head.length, head.data};
    assign m_axis_tlast  = head.run_last;
    assign m_axis_tuser  = head.done;

endmodule

`default_nettype wire

>>> rtl/sed_checker.sv
// Port-level checker for the string escape decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sed_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,
    input  wire logic        m_axis_tlast,
    input  wire logic        m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // end of string is always the last word of its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("string_done without run_last");

    // every delivered byte counts itself
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:8] != 16'd0)
        else $error("zero out_length on a result word");

    // with no result pending, the input side never stalls
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output queue empty");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
